// File: rtl/meu_pkg.sv
// Shared types and codes for the 68000 effective address unit.
// No dependencies; used by meu_calc and the top level.
package meu_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_JUMP  = 2'd2;

  localparam logic [3:0] MODE_DN       = 4'd0;
  localparam logic [3:0] MODE_AN       = 4'd1;
  localparam logic [3:0] MODE_AN_IND   = 4'd2;
  localparam logic [3:0] MODE_AN_POST  = 4'd3;
  localparam logic [3:0] MODE_AN_PRE   = 4'd4;
  localparam logic [3:0] MODE_AN_D16   = 4'd5;
  localparam logic [3:0] MODE_AN_IDX   = 4'd6;
  localparam logic [3:0] MODE_ABS_W    = 4'd7;
  localparam logic [3:0] MODE_ABS_L    = 4'd8;
  localparam logic [3:0] MODE_PC_D16   = 4'd9;
  localparam logic [3:0] MODE_PC_IDX   = 4'd10;
  localparam logic [3:0] MODE_IMM      = 4'd11;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;
  localparam logic [1:0] SIZE_LONG = 2'd2;

  localparam logic [1:0] KIND_MEM = 2'd0;
  localparam logic [1:0] KIND_REG = 2'd1;
  localparam logic [1:0] KIND_IMM = 2'd2;

  localparam logic [2:0] STACK_REG  = 3'd7;
  localparam int         REQ_BITS   = 141;
  localparam int         RES_BITS   = 73;

  typedef struct packed {
    logic [31:0] program_counter;
    logic [15:0] ext_word_low;
    logic [15:0] ext_word;
    logic [31:0] index_value;
    logic [31:0] base_value;
    logic        fast;
    logic        hold;
    logic [1:0]  size;
    logic [2:0]  reg_req;
    logic [3:0]  mode;
    logic [1:0]  operation;
  } req_t;

  typedef struct packed {
    logic        invalid;
    logic [2:0]  idle_cycles;
    logic [1:0]  words_used;
    logic [31:0] update_value;
    logic        update_reg;
    logic [1:0]  operand_kind;
    logic [31:0] address;
  } res_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage

// File: rtl/meu_stage.sv
// One valid/ready register stage of generic width.
// No dependencies.
module meu_stage #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= in_data;
    end
  end

endmodule

// File: rtl/meu_calc.sv
// Combinational effective address and operand calculation for one request.
// Depends on meu_pkg.
module meu_calc (
  input  meu_pkg::req_t req,
  output meu_pkg::res_t res
);

  logic [1:0]  sz;
  logic [2:0]  step;
  logic        pc_rel;
  logic [31:0] base_sel;
  logic [31:0] idx;
  logic [31:0] ext_sx;
  logic [31:0] d16_sum;
  logic [31:0] idx_sum;
  logic [31:0] abs_l;
  logic [31:0] post_sum;
  logic [31:0] pre_sum;
  logic [31:0] clip_base;
  logic [31:0] sign_base;
  logic [31:0] clip_ext;
  logic        inval;

  always_comb begin
    sz = (req.size == 2'd3) ? meu_pkg::SIZE_LONG : req.size;
    case (sz)
      meu_pkg::SIZE_BYTE: step = (req.reg_req == meu_pkg::STACK_REG) ? 3'd2 : 3'd1;
      meu_pkg::SIZE_WORD: step = 3'd2;
      default:            step = 3'd4;
    endcase
    pc_rel    = (req.mode == meu_pkg::MODE_PC_D16) || (req.mode == meu_pkg::MODE_PC_IDX);
    base_sel  = pc_rel ? (req.program_counter - 32'd2) : req.base_value;
    idx       = req.ext_word[11] ? req.index_value : meu_pkg::sext16(req.index_value[15:0]);
    ext_sx    = meu_pkg::sext16(req.ext_word);
    d16_sum   = base_sel + ext_sx;
    idx_sum   = base_sel + idx + meu_pkg::sext8(req.ext_word[7:0]);
    abs_l     = {req.ext_word, req.ext_word_low};
    post_sum  = req.base_value + {29'd0, step};
    pre_sum   = req.base_value - {29'd0, step};
    case (sz)
      meu_pkg::SIZE_BYTE: begin
        clip_base = {24'd0, req.base_value[7:0]};
        sign_base = meu_pkg::sext8(req.base_value[7:0]);
        clip_ext  = {24'd0, req.ext_word[7:0]};
      end
      meu_pkg::SIZE_WORD: begin
        clip_base = {16'd0, req.base_value[15:0]};
        sign_base = meu_pkg::sext16(req.base_value[15:0]);
        clip_ext  = {16'd0, req.ext_word};
      end
      default: begin
        clip_base = req.base_value;
        sign_base = req.base_value;
        clip_ext  = abs_l;
      end
    endcase

    res   = '0;
    inval = 1'b0;
    if (req.operation == meu_pkg::OP_JUMP) begin
      case (req.mode)
        meu_pkg::MODE_AN_IND: res.address = req.base_value;
        meu_pkg::MODE_AN_D16, meu_pkg::MODE_PC_D16: begin
          res.address = d16_sum; res.words_used = 2'd1; res.idle_cycles = 3'd2;
        end
        meu_pkg::MODE_AN_IDX, meu_pkg::MODE_PC_IDX: begin
          res.address = idx_sum; res.words_used = 2'd1; res.idle_cycles = 3'd6;
        end
        meu_pkg::MODE_ABS_W: begin
          res.address = ext_sx; res.words_used = 2'd1; res.idle_cycles = 3'd2;
        end
        meu_pkg::MODE_ABS_L: begin
          res.address = abs_l; res.words_used = 2'd2;
        end
        default: inval = 1'b1;
      endcase
    end else if (req.operation == meu_pkg::OP_READ || req.operation == meu_pkg::OP_WRITE) begin
      case (req.mode)
        meu_pkg::MODE_DN: begin
          res.address = clip_base; res.operand_kind = meu_pkg::KIND_REG;
        end
        meu_pkg::MODE_AN: begin
          res.address = sign_base; res.operand_kind = meu_pkg::KIND_REG;
        end
        meu_pkg::MODE_AN_IND: res.address = req.base_value;
        meu_pkg::MODE_AN_POST: begin
          res.address = req.base_value;
          if (!req.hold) begin
            res.update_reg = 1'b1; res.update_value = post_sum;
          end
        end
        meu_pkg::MODE_AN_PRE: begin
          res.address = pre_sum;
          if (req.operation == meu_pkg::OP_READ && !req.fast) res.idle_cycles = 3'd2;
          if (!req.hold) begin
            res.update_reg = 1'b1; res.update_value = pre_sum;
          end
        end
        meu_pkg::MODE_AN_D16, meu_pkg::MODE_PC_D16: begin
          res.address = d16_sum; res.words_used = 2'd1;
        end
        meu_pkg::MODE_AN_IDX, meu_pkg::MODE_PC_IDX: begin
          res.address = idx_sum; res.words_used = 2'd1; res.idle_cycles = 3'd2;
        end
        meu_pkg::MODE_ABS_W: begin
          res.address = ext_sx; res.words_used = 2'd1;
        end
        meu_pkg::MODE_ABS_L: begin
          res.address = abs_l; res.words_used = 2'd2;
        end
        meu_pkg::MODE_IMM: begin
          res.address      = clip_ext;
          res.operand_kind = meu_pkg::KIND_IMM;
          res.words_used   = (sz == meu_pkg::SIZE_LONG) ? 2'd2 : 2'd1;
        end
        default: inval = 1'b1;
      endcase
    end else begin
      inval = 1'b1;
    end

    if (inval) begin
      res         = '0;
      res.invalid = 1'b1;
    end
  end

endmodule

// File: rtl/m68000_effective_address_unit.sv
// Top level of the 68000 effective address unit: input stage, calculation, result stage.
// Depends on meu_pkg, meu_stage and meu_calc.
//
// Usage:
//   s_* carries one addressing request per beat, m_* one result per beat.
//   A beat moves when tvalid and tready are both high at a rising clk edge.
//   The request is registered in the input stage when accepted, the address is computed
//   by the adders between the two registers, and the result is registered in
//   the result stage once that stage has room, which raises m_tvalid.
//   Throughput is one beat per cycle while m_tready stays high.
//   When the receiver drops m_tready, the result stage holds its beat, the
//   input stage fills, and s_tready falls once both are full; no beat is
//   lost or repeated. The block keeps no other state.
//   rst (synchronous, active high) empties both stages, so s_tready is high
//   as soon as reset is released.
//   Invalid requests (unusable mode, a non-jump mode for a jump target, or an
//   undefined operation code) return a beat with invalid set and all other fields zero.
module m68000_effective_address_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // operation[1:0] mode[5:2] reg_req[8:6] size[10:9] hold[11] fast[12]
  // base_value[44:13] index_value[76:45] ext_word[92:77] ext_word_low[108:93]
  // program_counter[140:109], zero pad [143:141]
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // address[31:0] update_reg[32] update_value[64:33] words_used[66:65]
  // idle_cycles[69:67] invalid[70], zero pad [71]
  output logic [71:0]  m_tdata,
  // operand_kind[1:0]
  output logic [1:0]   m_tuser
);

  logic                          req_valid;
  logic                          req_ready;
  logic [meu_pkg::REQ_BITS-1:0]  req_data;
  meu_pkg::req_t                 req;
  meu_pkg::res_t                 res;
  logic [meu_pkg::RES_BITS-1:0]  res_data;
  logic [meu_pkg::RES_BITS-1:0]  out_data;

  meu_stage #(.W(meu_pkg::REQ_BITS)) u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata[meu_pkg::REQ_BITS-1:0]),
    .out_valid (req_valid),
    .out_ready (req_ready),
    .out_data  (req_data)
  );

  assign req = meu_pkg::req_t'(req_data);

  meu_calc u_calc (
    .req (req),
    .res (res)
  );

  assign res_data = res;

  meu_stage #(.W(meu_pkg::RES_BITS)) u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_ready  (req_ready),
    .in_data   (res_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {1'b0, out_data[72:34], out_data[31:0]};
  assign m_tuser = out_data[33:32];

endmodule
